/* rtl/fsla_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsla_pkg
// Shared types and constants for the fixed-slot free-list allocator.
// ----------------------------------------------------------------------------
package fsla_pkg;

    localparam int BLOCK_BYTES   = 4096;
    localparam int MAX_SLOTS_DEF = 512;

    localparam int ELEM_W   = 13;
    localparam int OFFS_W   = 12;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 10;
    localparam int QUO_W    = 9;
    localparam int DVD_W    = 13;
    localparam int STEP_W   = $clog2(DVD_W);

    localparam logic [ELEM_W-1:0] ELEM_RESET = ELEM_W'(64);
    localparam logic [ELEM_W-1:0] ELEM_MIN   = ELEM_W'(8);
    localparam logic [DVD_W-1:0]  BLOCK_DVD  = DVD_W'(BLOCK_BYTES);
    localparam logic [OFFS_W-1:0] OFFS_MASK  = OFFS_W'(BLOCK_BYTES - 1);

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic              command;
        logic [OFFS_W-1:0] release_offset;
    } t_in_item;

    typedef struct packed {
        logic [OFFS_W-1:0]   slot_offset;
        logic [STATUS_W-1:0] status;
        logic                now_empty;
        logic                now_all_free;
        logic [COUNT_W-1:0]  free_count;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic init_load;
        logic init_end;
        logic rel_load;
        logic div_step;
        logic pop;
        logic mul;
        logic push;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_alloc;
        logic is_fail;
        logic div_last;
        logic out_free;
    } t_dp_stat;

endpackage

/* rtl/fsla_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsla_ctrl
// Sequencer for the allocator: list rebuild, item decode, divide, stack
// access and result hand-off.
// ----------------------------------------------------------------------------
module fsla_ctrl
    import fsla_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_cfg_wr_en,
    input  t_dp_stat i_stat,
    output logic     o_in_stall,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_INIT_DIV,
        S_INIT_END,
        S_IDLE,
        S_DECODE,
        S_DIV_LOAD,
        S_DIV,
        S_PUSH,
        S_POP,
        S_MUL,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT:     n_state = S_INIT_DIV;
            S_INIT_DIV: if (i_stat.div_last) n_state = S_INIT_END;
            S_INIT_END: n_state = S_IDLE;
            S_IDLE:     if (i_in_valid) n_state = S_DECODE;
            S_DECODE: begin
                if (i_stat.is_fail) begin
                    n_state = S_DONE;
                end else if (i_stat.is_alloc) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_DIV_LOAD;
                end
            end
            S_DIV_LOAD: n_state = S_DIV;
            S_DIV:      if (i_stat.div_last) n_state = S_PUSH;
            S_PUSH:     n_state = S_DONE;
            S_POP:      n_state = S_MUL;
            S_MUL:      n_state = S_DONE;
            S_DONE:     if (i_stat.out_free) n_state = S_IDLE;
            default:    n_state = S_INIT;
        endcase
        if (i_cfg_wr_en) begin
            n_state = S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.accept    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.init_load = (r_state == S_INIT);
        o_cmd.init_end  = (r_state == S_INIT_END);
        o_cmd.rel_load  = (r_state == S_DIV_LOAD);
        o_cmd.div_step  = (r_state == S_INIT_DIV) || (r_state == S_DIV);
        o_cmd.pop       = (r_state == S_POP);
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.push      = (r_state == S_PUSH);
        o_cmd.out_load  = (r_state == S_DONE) && i_stat.out_free;
    end

endmodule

/* rtl/fsla_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsla_dp
// Allocator datapath: element size, restoring divider, free-index stack with
// low-water mark, offset multiplier and result register.
// ----------------------------------------------------------------------------
module fsla_dp
    import fsla_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  t_in_item          i_in_data,
    input  logic              i_cfg_wr_en,
    input  logic [ELEM_W-1:0] i_cfg_wr_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data
);

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);

    logic [ELEM_W-1:0] r_elem;
    logic [CW-1:0]     r_slots;
    logic [CW-1:0]     r_top;
    logic [CW-1:0]     r_low;
    logic              r_cmd;
    logic [OFFS_W-1:0] r_offs;
    t_status           r_status;
    t_status           n_status;

    logic [DVD_W-1:0]  r_dvd;
    logic [ELEM_W-1:0] r_rem;
    logic [STEP_W-1:0] r_cnt;
    logic [ELEM_W:0]   rem_sh;
    logic              q_bit;

    logic [QUO_W-1:0]  r_mem [MAX_SLOTS];
    logic [QUO_W-1:0]  r_rd;
    logic [IW-1:0]     r_pos;
    logic              r_ident;
    logic [CW-1:0]     pop_pos;
    logic              pop_ident;

    logic [QUO_W-1:0]        idx;
    logic [QUO_W+ELEM_W-1:0] prod_full;
    logic [OFFS_W-1:0]       r_prod;
    logic [CW-1:0]           slots_capped;

    logic      r_out_valid;
    t_out_item r_out;

    always_comb begin
        n_status = STAT_OK;
        if ((i_in_data.command == CMD_ALLOC) && (r_top == '0)) begin
            n_status = STAT_EMPTY;
        end else if ((i_in_data.command == CMD_RELEASE) && (r_top >= r_slots)) begin
            n_status = STAT_FULL;
        end
    end

    assign rem_sh = {r_rem, r_dvd[DVD_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_elem});

    assign slots_capped = (32'(r_dvd) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(r_dvd);

    assign pop_pos   = r_top - 1'b1;
    assign pop_ident = (pop_pos < r_low);

    assign idx       = r_ident ? QUO_W'(r_pos) : r_rd;
    assign prod_full = idx * r_elem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem      <= ELEM_RESET;
            r_slots     <= '0;
            r_top       <= '0;
            r_low       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_elem <= (i_cfg_wr_data < ELEM_MIN) ? ELEM_MIN : i_cfg_wr_data;
            end
            if (i_cmd.init_load || i_cmd.rel_load) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.init_end) begin
                r_slots <= slots_capped;
                r_top   <= slots_capped;
                r_low   <= slots_capped;
            end
            if (i_cmd.pop) begin
                r_top <= pop_pos;
                if (pop_ident) begin
                    r_low <= pop_pos;
                end
            end
            if (i_cmd.push) begin
                r_top <= r_top + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd    <= i_in_data.command;
            r_offs   <= i_in_data.release_offset;
            r_status <= n_status;
        end
        if (i_cmd.init_load) begin
            r_dvd <= BLOCK_DVD;
            r_rem <= '0;
        end else if (i_cmd.rel_load) begin
            r_dvd <= DVD_W'(r_offs & OFFS_MASK);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[DVD_W-2:0], q_bit};
            r_rem <= q_bit ? ELEM_W'(rem_sh - {1'b0, r_elem}) : rem_sh[ELEM_W-1:0];
        end
        if (i_cmd.pop) begin
            r_pos   <= pop_pos[IW-1:0];
            r_ident <= pop_ident;
        end
        if (i_cmd.mul) begin
            r_prod <= prod_full[OFFS_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out.slot_offset  <= ((r_cmd == CMD_ALLOC) && (r_status == STAT_OK)) ?
                                  r_prod : '0;
            r_out.status       <= r_status;
            r_out.now_empty    <= (r_top == '0);
            r_out.now_all_free <= (r_top == r_slots);
            r_out.free_count   <= COUNT_W'(r_top);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_top[IW-1:0]] <= r_dvd[QUO_W-1:0];
        end
        if (i_cmd.pop) begin
            r_rd <= r_mem[pop_pos[IW-1:0]];
        end
    end

    assign o_stat.is_alloc = (r_cmd == CMD_ALLOC);
    assign o_stat.is_fail  = (r_status != STAT_OK);
    assign o_stat.div_last = (r_cnt == STEP_W'(DVD_W - 1));
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_top_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= r_slots)
        else $error("free count above slot count");

    a_low_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_slots)
        else $error("low-water mark above slot count");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_top != '0))
        else $error("pop from empty stack");

    a_push_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push && !i_cfg_wr_en |=> (r_top == $past(r_top) + 1'b1))
        else $error("push did not advance stack top");

endmodule

/* rtl/fixed_slot_free_list_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator
// LIFO free-list slab allocator over one block cut into equal slots.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_data): command 0 allocates a
// slot, command 1 releases the slot at release_offset. Output channel
// (o_out_valid / i_out_stall / o_out_data): one result per transfer, with the
// slot byte offset, status and free-list occupancy.
// From input transfer to result valid, an allocate runs decode, stack read,
// multiply and load; a release runs decode, divider load, 13 restoring
// divider steps, push and load; a flagged item runs decode and load. The
// 13-step divider makes a release the longest operation. One item is in
// work at a time; the next is taken the cycle after its result is loaded.
// At reset, and after every write of i_cfg_wr_en / i_cfg_wr_data, the slot
// count is rebuilt with the same divider: o_in_stall stays high throughout.
// The result register decouples the sides: an item is accepted while the
// previous result waits, and a stalled result holds until transferred.
// ----------------------------------------------------------------------------
module fixed_slot_free_list_allocator
    import fsla_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              i_cfg_wr_en,
    input  logic [ELEM_W-1:0] i_cfg_wr_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    fsla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_stat      (dp_stat),
        .o_in_stall  (o_in_stall),
        .o_cmd       (dp_cmd)
    );

    fsla_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_in_data     (i_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

endmodule
